// File: rtl/mitchell_filter_weight_unit_macros.svh
// Assertion macros for the Mitchell filter weight unit.
// Used by the top level; expects signals clk and rst_n in the including scope.
`ifndef MITCHELL_FILTER_WEIGHT_UNIT_MACROS_SVH
`define MITCHELL_FILTER_WEIGHT_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define MFW_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mitchell filter weight unit: assertion failed");
// Next-cycle implication, checked outside reset.
`define MFW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mitchell filter weight unit: assertion failed");
`else
`define MFW_ASSERT_IMPLY(label, ante, cons)
`define MFW_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/mfw_pkg.sv
// Package for the Mitchell filter weight unit: widths, constants, register codes
// and the structs shared between the pipeline modules. No dependencies.
package mfw_pkg;

  // Field and datapath widths
  localparam int OFS_W   = 16;                 // Q4.12 offset
  localparam int CFG_W   = 16;                 // register data
  localparam int IDX_W   = 4;                  // register index
  localparam int T_W     = 18;                 // t in Q16, 0 .. 2.0
  localparam int T2_W    = 19;                 // t^2 in Q16, 0 .. 4.0
  localparam int T3_W    = 20;                 // t^3 in Q16, 0 .. 8.0
  localparam int COEF_W  = 24;                 // cubic coefficients in Q15
  localparam int TERM_W  = COEF_W + T3_W + 1;  // one product term in Q31
  localparam int SUM_W   = TERM_W + 2;         // sum of four terms
  localparam int AXIS_W  = 28;                 // axis cubic in Q16
  localparam int PROD_W  = 2 * AXIS_W;         // product of both axes, Q32
  localparam int W_W     = 32;                 // weight in Q15.16
  localparam int NUM_STG = 7;                  // pipeline stages

  localparam logic [T_W-1:0] T_MAX = T_W'(131072);

  // Integer constants of the cubic, in the coefficient width
  localparam logic signed [COEF_W-1:0] Q15_ONE = COEF_W'(32768);
  localparam logic signed [COEF_W-1:0] K2  = COEF_W'(2);
  localparam logic signed [COEF_W-1:0] K6  = COEF_W'(6);
  localparam logic signed [COEF_W-1:0] K8  = COEF_W'(8);
  localparam logic signed [COEF_W-1:0] K9  = COEF_W'(9);
  localparam logic signed [COEF_W-1:0] K12 = COEF_W'(12);
  localparam logic signed [COEF_W-1:0] K18 = COEF_W'(18);
  localparam logic signed [COEF_W-1:0] K24 = COEF_W'(24);
  localparam logic signed [COEF_W-1:0] K30 = COEF_W'(30);
  localparam logic signed [COEF_W-1:0] K48 = COEF_W'(48);

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_PARAM_B      = 4'd0,
    REG_PARAM_C      = 4'd1,
    REG_INV_RADIUS_X = 4'd2,
    REG_INV_RADIUS_Y = 4'd3
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] RST_PARAM_B = 16'd10923;
  localparam logic [CFG_W-1:0] RST_PARAM_C = 16'd10923;
  localparam logic [CFG_W-1:0] RST_INV_RAD = 16'd2048;

  // Coefficients of both cubic pieces
  typedef struct packed {
    logic signed [COEF_W-1:0] in_a3;
    logic signed [COEF_W-1:0] in_a2;
    logic signed [COEF_W-1:0] in_a0;
    logic signed [COEF_W-1:0] out_a3;
    logic signed [COEF_W-1:0] out_a2;
    logic signed [COEF_W-1:0] out_a1;
    logic signed [COEF_W-1:0] out_a0;
  } coef_set_t;

  // Pipeline control from the controller to the datapath
  typedef struct packed {
    logic [NUM_STG-1:0] load;
    logic [NUM_STG-1:0] vld;
  } pipe_ctl_t;

endpackage

// File: rtl/mfw_coef.sv
// Configuration registers and the cubic coefficients derived from B and C.
// Depends on mfw_pkg.
module mfw_coef (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  input  logic [mfw_pkg::IDX_W-1:0]    cfg_index,
  input  logic [mfw_pkg::CFG_W-1:0]    cfg_data,
  output logic [mfw_pkg::CFG_W-1:0]    inv_x,
  output logic [mfw_pkg::CFG_W-1:0]    inv_y,
  output mfw_pkg::coef_set_t           coef
);
  import mfw_pkg::*;

  logic [CFG_W-1:0] param_b_r, param_c_r, inv_x_r, inv_y_r;
  logic signed [COEF_W-1:0] bs, cs;
  coef_set_t coef_r, coef_nxt;

  // Register writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      param_b_r <= RST_PARAM_B;
      param_c_r <= RST_PARAM_C;
      inv_x_r   <= RST_INV_RAD;
      inv_y_r   <= RST_INV_RAD;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PARAM_B:      param_b_r <= cfg_data;
        REG_PARAM_C:      param_c_r <= cfg_data;
        REG_INV_RADIUS_X: inv_x_r   <= cfg_data;
        REG_INV_RADIUS_Y: inv_y_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Coefficients in Q15; the factor of 6 of the normalization is kept.
  always_comb begin
    bs = $signed({{(COEF_W-CFG_W){1'b0}}, param_b_r});
    cs = $signed({{(COEF_W-CFG_W){1'b0}}, param_c_r});
    coef_nxt.in_a3  = K12 * Q15_ONE - K9 * bs - K6 * cs;
    coef_nxt.in_a2  = K12 * bs + K6 * cs - K18 * Q15_ONE;
    coef_nxt.in_a0  = K6 * Q15_ONE - K2 * bs;
    coef_nxt.out_a3 = -bs - K6 * cs;
    coef_nxt.out_a2 = K6 * bs + K30 * cs;
    coef_nxt.out_a1 = -(K12 * bs) - K48 * cs;
    coef_nxt.out_a0 = K8 * bs + K24 * cs;
  end

  // Registered always; user changes registers only with block idle; unchecked.
  always_ff @(posedge clk) begin
    coef_r <= coef_nxt;
  end

  assign inv_x = inv_x_r;
  assign inv_y = inv_y_r;
  assign coef  = coef_r;

endmodule

// File: rtl/mfw_ctrl.sv
// Pipeline controller: valid bits per stage and bubble-collapsing load enables.
// Depends on mfw_pkg.
module mfw_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               out_stall,
  output logic               out_valid,
  output mfw_pkg::pipe_ctl_t ctl
);
  import mfw_pkg::*;

  logic [NUM_STG-1:0] v_r, v_nxt, adv;

  // A stage advances when it is empty or the stage after it advances.
  always_comb begin
    adv[NUM_STG-1] = !v_r[NUM_STG-1] || !out_stall;
    for (int i = NUM_STG - 2; i >= 0; i--) begin
      adv[i] = !v_r[i] || adv[i+1];
    end
  end

  // Valid bits move along with the data.
  always_comb begin
    v_nxt[0] = adv[0] ? in_valid : v_r[0];
    for (int i = 1; i < NUM_STG; i++) begin
      v_nxt[i] = adv[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !adv[0] || !rst_n;
  assign out_valid = v_r[NUM_STG-1];
  assign ctl.load  = adv;
  assign ctl.vld   = v_r;

endmodule

// File: rtl/mfw_axis.sv
// One axis of the filter: t from the offset, powers of t, cubic terms and sum.
// Five pipeline stages; depends on mfw_pkg.
module mfw_axis (
  input  logic                               clk,
  input  mfw_pkg::pipe_ctl_t                 ctl,
  input  logic signed [mfw_pkg::OFS_W-1:0]   offset,
  input  logic [mfw_pkg::CFG_W-1:0]          inv,
  input  mfw_pkg::coef_set_t                 coef,
  output logic signed [mfw_pkg::AXIS_W-1:0]  wx
);
  import mfw_pkg::*;

  localparam int MP_W = OFS_W + CFG_W;

  // Stage 0: magnitude, scaling and clamp to the support
  logic [OFS_W-1:0] mag;
  logic [MP_W-1:0]  mp;
  logic [MP_W-8:0]  t_raw;
  logic [T_W-1:0]   t0_nxt, t0_r;

  always_comb begin
    mag    = offset[OFS_W-1] ? OFS_W'(-offset) : offset;
    mp     = MP_W'(mag) * MP_W'(inv);
    t_raw  = mp[MP_W-1:7];
    t0_nxt = (t_raw > (MP_W-7)'(T_MAX)) ? T_MAX : t_raw[T_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.load[0]) t0_r <= t0_nxt;
  end

  // Stage 1: t squared
  logic [2*T_W-1:0] sq;
  logic [T_W-1:0]   t1_r;
  logic [T2_W-1:0]  t2a_r;

  assign sq = (2*T_W)'(t0_r) * (2*T_W)'(t0_r);

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      t1_r  <= t0_r;
      t2a_r <= sq[T2_W+15:16];
    end
  end

  // Stage 2: t cubed and choice of the piece
  localparam int CU_W = T2_W + T_W;
  logic [CU_W-1:0] cu;
  logic [T_W-1:0]  t2_t_r;
  logic [T2_W-1:0] t2_r;
  logic [T3_W-1:0] t3_r;
  logic            inner_r;

  assign cu = CU_W'(t2a_r) * CU_W'(t1_r);

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      t2_t_r  <= t1_r;
      t2_r    <= t2a_r;
      t3_r    <= cu[T3_W+15:16];
      inner_r <= (t1_r[T_W-1:16] == '0);
    end
  end

  // Stage 3: the three products and the constant term
  logic signed [COEF_W-1:0] a3, a2, a1;
  logic signed [TERM_W-1:0] p3_r, p2_r, p1_r;
  logic signed [COEF_W-1:0] p0_r;

  always_comb begin
    a3 = inner_r ? coef.in_a3 : coef.out_a3;
    a2 = inner_r ? coef.in_a2 : coef.out_a2;
    a1 = inner_r ? '0 : coef.out_a1;
  end

  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      p3_r <= TERM_W'(a3) * TERM_W'($signed({1'b0, t3_r}));
      p2_r <= TERM_W'(a2) * TERM_W'($signed({1'b0, t2_r}));
      p1_r <= TERM_W'(a1) * TERM_W'($signed({1'b0, t2_t_r}));
      p0_r <= inner_r ? coef.in_a0 : coef.out_a0;
    end
  end

  // Stage 4: exact Q31 sum, floored to Q16
  logic signed [SUM_W-1:0] sum;
  logic signed [AXIS_W-1:0] wx_r;

  assign sum = SUM_W'(p3_r) + SUM_W'(p2_r) + SUM_W'(p1_r) + (SUM_W'(p0_r) <<< 16);

  always_ff @(posedge clk) begin
    if (ctl.load[4]) wx_r <= sum[15 +: AXIS_W];
  end

  assign wx = wx_r;

endmodule

// File: rtl/mitchell_filter_weight_unit.sv
// Top level of the Mitchell-Netravali filter weight unit: configuration,
// two axis pipelines, the final product and saturation. Depends on mfw_pkg,
// mfw_coef, mfw_ctrl, mfw_axis and mitchell_filter_weight_unit_macros.svh.
//
//   channel  ports                                     direction  handshake
//   in       in_offset_x, in_offset_y                  input      in_valid / in_stall
//   out      out_weight                                output     out_valid / out_stall
//   cfg      cfg_index, cfg_data                       input      cfg_valid / cfg_ready
//
// One item enters per cycle while in_stall is low. The edge that takes an item loads
// the first of seven register stages, and its weight leaves from the last of them.
// Reset is synchronous: it empties the pipeline and loads the default registers.
// A stall on the output holds the last stage; earlier empty stages still fill,
// so outside reset the input stalls only when all seven stages hold items.
// cfg_ready is high outside reset; writes are registered, B and C again in coef_r.
module mitchell_filter_weight_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [mfw_pkg::OFS_W-1:0]  in_offset_x,
  input  logic signed [mfw_pkg::OFS_W-1:0]  in_offset_y,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [mfw_pkg::W_W-1:0]    out_weight,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mfw_pkg::IDX_W-1:0]         cfg_index,
  input  logic [mfw_pkg::CFG_W-1:0]         cfg_data
);
  import mfw_pkg::*;
  `include "mitchell_filter_weight_unit_macros.svh"

  localparam int SH_W = PROD_W - 16;

  logic [CFG_W-1:0]         inv_x, inv_y;
  coef_set_t                coef;
  pipe_ctl_t                ctl;
  logic signed [AXIS_W-1:0] wx, wy;

  assign cfg_ready = rst_n;

  // Configuration registers and coefficients
  mfw_coef u_coef (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .inv_x     (inv_x),
    .inv_y     (inv_y),
    .coef      (coef)
  );

  // Stage valids and load enables
  mfw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .ctl       (ctl)
  );

  // One pipeline per axis
  mfw_axis u_axis_x (
    .clk    (clk),
    .ctl    (ctl),
    .offset (in_offset_x),
    .inv    (inv_x),
    .coef   (coef),
    .wx     (wx)
  );

  mfw_axis u_axis_y (
    .clk    (clk),
    .ctl    (ctl),
    .offset (in_offset_y),
    .inv    (inv_y),
    .coef   (coef),
    .wx     (wy)
  );

  // Stage 5: product of both axes in Q32
  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (ctl.load[5]) prod_r <= PROD_W'(wx) * PROD_W'(wy);
  end

  // Stage 6: floor to Q16 and saturate to 32 bits
  logic signed [SH_W-1:0] sh;
  logic [SH_W-W_W:0]      hi;
  logic signed [W_W-1:0]  weight_nxt, weight_r;

  always_comb begin
    sh = prod_r[PROD_W-1:16];
    hi = sh[SH_W-1:W_W-1];
    if ((&hi) || !(|hi)) begin
      weight_nxt = sh[W_W-1:0];
    end else if (sh[SH_W-1]) begin
      weight_nxt = {1'b1, {(W_W-1){1'b0}}};
    end else begin
      weight_nxt = {1'b0, {(W_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[6]) weight_r <= weight_nxt;
  end

  assign out_weight = weight_r;

  // Checks on the pipeline control
  logic in_fire, out_fire;
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;

  `MFW_ASSERT_IMPLY(a_stall_only_when_full, in_stall, &ctl.vld)
  `MFW_ASSERT_NEXT(a_accept_enters_stage0, in_fire, ctl.vld[0])
  `MFW_ASSERT_IMPLY(a_item_count_kept, $past(rst_n), $countones(ctl.vld) == $countones($past(ctl.vld)) + $past(in_fire) - $past(out_fire))

endmodule
